// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the tag extractor modules
// expects signals named clock and reset in the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define EST_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent implies consequent in the following cycle
`define EST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/est_pkg.sv =====
// types, character codes and helpers for the edit string tag extractor
// no dependencies
package est_pkg;

   localparam int TAG_LENGTH_DEF = 10;
   localparam int RUN_LENGTH_DEF = 6;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_PAD   = 8'h4E;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_MATCH = 8'h3D;
   localparam logic [7:0] CH_INS   = 8'h2B;
   localparam logic [7:0] CH_DEL   = 8'h2D;
   localparam logic [7:0] CH_SUB   = 8'h2A;

   typedef struct packed {
      logic [7:0] edit_char;
      logic       record_end;
   } req_type;

   typedef struct packed {
      logic [7:0] tag_char;
      logic       tag_last;
   } rsp_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7A) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/est_core.sv =====
// edit op decode, read rebuild, t run search and tag capture state
// depends on est_pkg and assert_macros.svh
module est_core
   import est_pkg::*;
#(
   parameter int TAG_LENGTH = TAG_LENGTH_DEF,
   parameter int RUN_LENGTH = RUN_LENGTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  req_type                     in_data,
   input  logic                        advance,
   output logic                        emit,
   output logic [TAG_LENGTH-1:0][7:0]  tags
);

   `include "assert_macros.svh"

   localparam int CNT_W  = $clog2(TAG_LENGTH + 1);
   localparam int TRUN_W = $clog2(RUN_LENGTH + 1);

   typedef enum logic [2:0] {
      MODE_NONE,
      MODE_MATCH,
      MODE_INS,
      MODE_DEL,
      MODE_SUB_SKIP,
      MODE_SUB_KEEP
   } mode_type;

   mode_type                    mode_ff, mode_in;
   logic [TRUN_W-1:0]           t_run_ff, t_run_in, t_inc;
   logic                        found_ff, found_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [TAG_LENGTH-1:0][7:0]  store_ff, store_in;
   logic                        keep;
   logic [7:0]                  c, u;

   assign c     = in_data.edit_char;
   assign u     = to_upper(c);
   assign t_inc = t_run_ff + TRUN_W'(1);

   always_comb begin
      mode_in  = mode_ff;
      t_run_in = t_run_ff;
      found_in = found_ff;
      cnt_in   = cnt_ff;
      store_in = store_ff;
      keep     = 1'b0;
      priority if (c == CH_NUL) begin
         mode_in = MODE_NONE;
      end else if (mode_ff == MODE_SUB_SKIP) begin
         mode_in = MODE_SUB_KEEP;
      end else if (mode_ff == MODE_SUB_KEEP) begin
         keep    = 1'b1;
         mode_in = MODE_NONE;
      end else if (c == CH_MATCH) begin
         mode_in = MODE_MATCH;
      end else if (c == CH_INS) begin
         mode_in = MODE_INS;
      end else if (c == CH_DEL) begin
         mode_in = MODE_DEL;
      end else if (c == CH_SUB) begin
         mode_in = MODE_SUB_SKIP;
      end else if (is_letter(c)) begin
         keep = (mode_ff == MODE_MATCH) || (mode_ff == MODE_INS);
      end else begin
         mode_in = MODE_NONE;
      end

      if (keep) begin
         if (found_ff) begin
            if (cnt_ff < CNT_W'(TAG_LENGTH)) begin
               for (int k = 0; k < TAG_LENGTH; k++) begin
                  if (cnt_ff == CNT_W'(k)) begin
                     store_in[k] = u;
                  end
               end
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end else if (u == CH_T) begin
            if (t_inc >= TRUN_W'(RUN_LENGTH)) begin
               found_in = 1'b1;
               t_run_in = '0;
            end else begin
               t_run_in = t_inc;
            end
         end else begin
            t_run_in = '0;
         end
      end
   end

   // positions not captured read as pad
   always_comb begin
      for (int k = 0; k < TAG_LENGTH; k++) begin
         tags[k] = (CNT_W'(k) < cnt_in) ? store_in[k] : CH_PAD;
      end
   end

   assign emit = in_valid && in_data.record_end && found_in && (tags[0] != CH_PAD);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NONE;
         t_run_ff <= '0;
         found_ff <= 1'b0;
         cnt_ff   <= '0;
      end else if (advance) begin
         if (in_data.record_end) begin
            mode_ff  <= MODE_NONE;
            t_run_ff <= '0;
            found_ff <= 1'b0;
            cnt_ff   <= '0;
         end else begin
            mode_ff  <= mode_in;
            t_run_ff <= t_run_in;
            found_ff <= found_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         store_ff <= store_in;
      end
   end

   `EST_ASSERT(a_cnt_range, cnt_ff <= CNT_W'(TAG_LENGTH), "capture count out of range")
   `EST_ASSERT(a_cnt_needs_run, !found_ff -> (cnt_ff == '0), "capture before run found")
   `EST_ASSERT(a_run_range, t_run_ff < TRUN_W'(RUN_LENGTH), "t run count out of range")

endmodule

// ===== rtl/core/est_burst.sv =====
// result buffer that shifts out one tag character per accepted word
// depends on est_pkg and assert_macros.svh
module est_burst
   import est_pkg::*;
#(
   parameter int TAG_LENGTH = TAG_LENGTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  logic [TAG_LENGTH-1:0][7:0]  tags,
   output logic                        free,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output rsp_type                     rsp_data
);

   `include "assert_macros.svh"

   localparam int CNT_W = $clog2(TAG_LENGTH + 1);

   logic [CNT_W-1:0]            rem_ff;
   logic [TAG_LENGTH-1:0][7:0]  buf_ff, buf_in;
   logic                        take;

   assign rsp_valid         = rem_ff != '0;
   assign take              = rsp_valid && rsp_ready;
   assign rsp_data.tag_char = buf_ff[0];
   assign rsp_data.tag_last = rem_ff == CNT_W'(1);
   assign free              = (rem_ff == '0) || ((rem_ff == CNT_W'(1)) && rsp_ready);

   always_comb begin
      buf_in = buf_ff;
      for (int k = 0; k < TAG_LENGTH - 1; k++) begin
         buf_in[k] = buf_ff[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= '0;
      end else if (load) begin
         rem_ff <= CNT_W'(TAG_LENGTH);
      end else if (take) begin
         rem_ff <= rem_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         buf_ff <= tags;
      end else if (take) begin
         buf_ff <= buf_in;
      end
   end

   `EST_ASSERT(a_rem_range, rem_ff <= CNT_W'(TAG_LENGTH), "burst count out of range")
   `EST_ASSERT(a_load_free, load -> free, "burst loaded while busy")
   `EST_ASSERT_NEXT(a_last_ends, take && rsp_data.tag_last,
      (rem_ff == '0) || (rem_ff == CNT_W'(TAG_LENGTH)), "burst did not end after last word")

endmodule

// ===== rtl/core/edit_string_tag_extractor.sv =====
// channel  dir  handshake            payload
// req      in   req_valid/req_ready  edit_char, record_end
// rsp      out  rsp_valid/rsp_ready  tag_char, tag_last
// one character per cycle unless a burst stall holds the input register; a character
// goes from the input register to the state registers, and a yielding record end
// loads a ten word burst, shifted out one word a cycle while rsp_ready is high
// a second yielding record end stalls only while the previous burst still drains
// synchronous active high reset clears all control state; no clearing pass
// depends on est_pkg, est_core and est_burst
module edit_string_tag_extractor
   import est_pkg::*;
#(
   parameter int TAG_LENGTH = TAG_LENGTH_DEF,
   parameter int RUN_LENGTH = RUN_LENGTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   logic                        in_valid_ff;
   req_type                     in_data_ff;
   logic                        emit, free, advance;
   logic [TAG_LENGTH-1:0][7:0]  tags;

   assign advance   = in_valid_ff && (!emit || free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   est_core #(
      .TAG_LENGTH (TAG_LENGTH),
      .RUN_LENGTH (RUN_LENGTH)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .in_valid (in_valid_ff),
      .in_data  (in_data_ff),
      .advance  (advance),
      .emit     (emit),
      .tags     (tags)
   );

   est_burst #(
      .TAG_LENGTH (TAG_LENGTH)
   ) u_burst (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .tags      (tags),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
